/* sv/gic_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gic_pkg
// Shared constants, types and codes of the grid index and cell converter.
// ----------------------------------------------------------------------------
package gic_pkg;

  // Number of active axes (x slowest, then y, then z); the last active one
  // varies fastest.
  localparam int NUM_DIMS = 3;
  localparam int NUM_AXES = 3;

  // Field widths.
  localparam int COORD_W = 16;
  localparam int INDEX_W = 32;
  localparam int GUARD_W = 8;
  localparam int BOUND_W = 17;   // bound widened by the halo
  localparam int RES_W   = 17;   // resolution of a valid box axis
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Divider organization: radix-2 restoring steps, several per stage.
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES_PER_AXIS = INDEX_W / DIV_STEPS;
  localparam int NUM_DIV_STAGES = DIV_STAGES_PER_AXIS * NUM_AXES;
  localparam int STAGE_IDX_W = $clog2(NUM_DIV_STAGES);
  localparam int AXIS_SEL_LSB = $clog2(DIV_STAGES_PER_AXIS);

  // Stages at which the cell-to-index accumulation does its work.
  localparam logic [STAGE_IDX_W-1:0] ST_MUL_Y = STAGE_IDX_W'(0);
  localparam logic [STAGE_IDX_W-1:0] ST_ADD_Y = STAGE_IDX_W'(1);
  localparam logic [STAGE_IDX_W-1:0] ST_MUL_Z = STAGE_IDX_W'(2);
  localparam logic [STAGE_IDX_W-1:0] ST_ADD_Z = STAGE_IDX_W'(3);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD   = 3'd6;

  // Request type bits: bit 0 selects cell to index, bit 1 the full box.
  localparam int REQ_CELL_BIT = 0;
  localparam int REQ_FULL_BIT = 1;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_W-1:0] lower;
    logic [NUM_AXES-1:0][COORD_W-1:0] upper;
    logic [GUARD_W-1:0]               guard;
  } gic_cfg_t;

  // Per-transaction record that travels down the pipeline.
  typedef struct packed {
    logic                             to_cell;
    logic                             oob;
    logic [NUM_AXES-1:0][BOUND_W-1:0] lb;
    logic [NUM_AXES-1:0][RES_W-1:0]   res;
    logic [NUM_AXES-1:0][RES_W-1:0]   off;
    logic [INDEX_W-1:0]               num;
    logic [RES_W-1:0]                 rem;
    logic [RES_W-1:0]                 dvs;
    logic [NUM_AXES-1:0][COORD_W-1:0] coord;
    logic [INDEX_W-1:0]               acc;
  } gic_rec_t;

endpackage
`default_nettype wire

/* sv/gic_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gic_in_if / gic_out_if
// Valid/ready channels for requests and results of the converter.
// ----------------------------------------------------------------------------
interface gic_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        lin_index;
  logic signed [15:0] cell_x;
  logic signed [15:0] cell_y;
  logic signed [15:0] cell_z;

  modport source (output valid, req_type, lin_index, cell_x, cell_y, cell_z,
                  input ready);
  modport sink (input valid, req_type, lin_index, cell_x, cell_y, cell_z,
                output ready);
endinterface

interface gic_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic [31:0]        out_index;
  logic               out_of_bounds;

  modport source (output valid, out_x, out_y, out_z, out_index, out_of_bounds,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_index, out_of_bounds,
                output ready);
endinterface
`default_nettype wire

/* sv/gic_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gic_front
// First pipeline stage: box bounds, resolutions, bounds checks and offsets.
// ----------------------------------------------------------------------------
module gic_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire gic_pkg::gic_cfg_t   cfg,
  input  wire logic                in_valid,
  input  wire logic [1:0]          req_type,
  input  wire logic [31:0]         lin_index,
  input  wire logic [gic_pkg::NUM_AXES-1:0][gic_pkg::COORD_W-1:0] cell_in,
  output logic                     valid_r,
  output gic_pkg::gic_rec_t        rec_r
);

  gic_pkg::gic_rec_t rec_nxt;

  // Bounds, emptiness and cell checks per axis.
  always_comb begin
    logic [8:0]  g;
    logic [17:0] lb18;
    logic [17:0] ub18;
    logic [17:0] res18;
    logic [17:0] c18;
    logic [17:0] off18;
    logic        active;
    logic        bad;
    logic        is_cell;
    logic        any_bad;
    rec_nxt = '0;
    is_cell = req_type[gic_pkg::REQ_CELL_BIT];
    g = req_type[gic_pkg::REQ_FULL_BIT] ? {1'b0, cfg.guard} : 9'd0;
    any_bad = 1'b0;
    rec_nxt.to_cell = ~is_cell;
    rec_nxt.num = lin_index;
    rec_nxt.rem = '0;
    rec_nxt.acc = '0;
    for (int i = 0; i < gic_pkg::NUM_AXES; i++) begin
      active = (i < gic_pkg::NUM_DIMS);
      lb18 = {{2{cfg.lower[i][15]}}, cfg.lower[i]} - {9'd0, g};
      ub18 = {{2{cfg.upper[i][15]}}, cfg.upper[i]} + {9'd0, g};
      res18 = ub18 - lb18;
      c18 = {{2{cell_in[i][15]}}, cell_in[i]};
      off18 = c18 - lb18;
      if (is_cell) begin
        bad = ($signed(c18) < $signed(lb18)) || ($signed(c18) >= $signed(ub18));
      end else begin
        bad = res18[17] || (res18 == 18'd0);
      end
      if (active && bad) begin
        any_bad = 1'b1;
      end
      rec_nxt.lb[i]  = active ? lb18[16:0] : '0;
      rec_nxt.res[i] = active ? res18[16:0] : 17'd1;
      rec_nxt.off[i] = active ? off18[16:0] : '0;
    end
    rec_nxt.oob = any_bad;
    // A rejected request divides by one so the datapath stays well defined.
    if (any_bad) begin
      for (int i = 0; i < gic_pkg::NUM_AXES; i++) begin
        rec_nxt.res[i] = 17'd1;
      end
    end
    rec_nxt.dvs = rec_nxt.res[gic_pkg::NUM_AXES-1];
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec_r <= rec_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/gic_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gic_stage
// One divider stage: several restoring division steps, the hand-off between
// axes, and, in the early stages, one step of the cell-to-index accumulation.
// ----------------------------------------------------------------------------
module gic_stage (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                adv,
  input  wire logic [gic_pkg::STAGE_IDX_W-1:0]     stage_idx,
  input  wire logic                                in_valid,
  input  wire gic_pkg::gic_rec_t                   in_rec,
  output logic                                     valid_r,
  output gic_pkg::gic_rec_t                        rec_r
);

  localparam int SEL_W = gic_pkg::STAGE_IDX_W - gic_pkg::AXIS_SEL_LSB;

  gic_pkg::gic_rec_t rec_nxt;

  always_comb begin
    gic_pkg::gic_rec_t r;
    logic [gic_pkg::RES_W:0]   rr;
    logic [SEL_W-1:0]          div_axis;
    logic [1:0]                ax_prev;
    logic [1:0]                ax_next;
    r = in_rec;
    div_axis = stage_idx[gic_pkg::STAGE_IDX_W-1:gic_pkg::AXIS_SEL_LSB];
    ax_prev = 2'(gic_pkg::NUM_AXES - int'(div_axis));
    ax_next = 2'(gic_pkg::NUM_AXES - 1 - int'(div_axis));

    // Hand-off: finish the previous axis and start dividing by the next one.
    if ((stage_idx[gic_pkg::AXIS_SEL_LSB-1:0] == '0) && (div_axis != '0)) begin
      r.coord[ax_prev] = r.rem[15:0] + r.lb[ax_prev][15:0];
      r.rem = '0;
      r.dvs = r.res[ax_next];
    end

    // Restoring division steps, one quotient bit each.
    for (int k = 0; k < gic_pkg::DIV_STEPS; k++) begin
      rr = {r.rem, r.num[gic_pkg::INDEX_W-1]};
      if (rr >= {1'b0, r.dvs}) begin
        rr = rr - {1'b0, r.dvs};
        r.num = {r.num[gic_pkg::INDEX_W-2:0], 1'b1};
      end else begin
        r.num = {r.num[gic_pkg::INDEX_W-2:0], 1'b0};
      end
      r.rem = rr[gic_pkg::RES_W-1:0];
    end

    // Horner accumulation of the linear index for cell requests.
    case (stage_idx)
      gic_pkg::ST_MUL_Y: r.acc = {15'd0, r.off[0]} * {15'd0, r.res[1]};
      gic_pkg::ST_ADD_Y: r.acc = r.acc + {15'd0, r.off[1]};
      gic_pkg::ST_MUL_Z: r.acc = r.acc * {15'd0, r.res[2]};
      gic_pkg::ST_ADD_Z: r.acc = r.acc + {15'd0, r.off[2]};
      default: r.acc = r.acc;
    endcase

    rec_nxt = r;
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec_r <= rec_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/grid_index_cell_converter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grid_index_cell_converter_top
// Converts between a row-major linear index and a 3-D cell of a box.
// ----------------------------------------------------------------------------
// Pipeline: one front stage, 24 divider stages of four quotient bits each
// and one output register between accepted request and result.
// Throughput: one transaction per cycle; the pipeline halts as a whole while
// a result waits at the output.
// Reset: synchronous active-low; clears all valid bits and sets the box to
// lower 0, upper 1, guard 0.
// ----------------------------------------------------------------------------
module grid_index_cell_converter_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  gic_in_if.sink                                 in_ch,
  gic_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [gic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gic_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NS = gic_pkg::NUM_DIV_STAGES;

  gic_pkg::gic_cfg_t cfg_r;
  logic              adv;
  logic              out_valid_r;
  logic [NS:0]       stage_valid;
  gic_pkg::gic_rec_t stage_rec [NS+1];
  logic [gic_pkg::NUM_AXES-1:0][gic_pkg::COORD_W-1:0] cell_vec;

  logic signed [15:0] out_x_r;
  logic signed [15:0] out_y_r;
  logic signed [15:0] out_z_r;
  logic [31:0]        out_index_r;
  logic               out_oob_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lower <= '0;
      cfg_r.upper <= {gic_pkg::NUM_AXES{16'd1}};
      cfg_r.guard <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gic_pkg::CFG_LOWER_X: cfg_r.lower[0] <= cfg_data;
        gic_pkg::CFG_LOWER_Y: cfg_r.lower[1] <= cfg_data;
        gic_pkg::CFG_LOWER_Z: cfg_r.lower[2] <= cfg_data;
        gic_pkg::CFG_UPPER_X: cfg_r.upper[0] <= cfg_data;
        gic_pkg::CFG_UPPER_Y: cfg_r.upper[1] <= cfg_data;
        gic_pkg::CFG_UPPER_Z: cfg_r.upper[2] <= cfg_data;
        gic_pkg::CFG_GUARD:   cfg_r.guard <= cfg_data[gic_pkg::GUARD_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  // The whole pipeline moves whenever the output register can take data.
  assign adv = ~out_valid_r | out_ch.ready;
  assign in_ch.ready = adv;

  assign cell_vec[0] = in_ch.cell_x;
  assign cell_vec[1] = in_ch.cell_y;
  assign cell_vec[2] = in_ch.cell_z;

  gic_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .req_type  (in_ch.req_type),
    .lin_index (in_ch.lin_index),
    .cell_in   (cell_vec),
    .valid_r   (stage_valid[0]),
    .rec_r     (stage_rec[0])
  );

  // Divider chain: fastest axis first, then the slower ones.
  for (genvar j = 0; j < NS; j++) begin : g_stage
    gic_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .stage_idx (gic_pkg::STAGE_IDX_W'(j)),
      .in_valid  (stage_valid[j]),
      .in_rec    (stage_rec[j]),
      .valid_r   (stage_valid[j+1]),
      .rec_r     (stage_rec[j+1])
    );
  end

  // Output register: finish the slowest axis and select the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stage_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_oob_r <= stage_rec[NS].oob;
      if (stage_rec[NS].to_cell && !stage_rec[NS].oob) begin
        out_x_r <= stage_rec[NS].rem[15:0] + stage_rec[NS].lb[0][15:0];
        out_y_r <= stage_rec[NS].coord[1];
        out_z_r <= stage_rec[NS].coord[2];
      end else begin
        out_x_r <= '0;
        out_y_r <= '0;
        out_z_r <= '0;
      end
      if (!stage_rec[NS].to_cell && !stage_rec[NS].oob) begin
        out_index_r <= stage_rec[NS].acc;
      end else begin
        out_index_r <= '0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_x         = out_x_r;
  assign out_ch.out_y         = out_y_r;
  assign out_ch.out_z         = out_z_r;
  assign out_ch.out_index     = out_index_r;
  assign out_ch.out_of_bounds = out_oob_r;

endmodule
`default_nettype wire

/* test/tb_grid_index_cell_converter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_grid_index_cell_converter_top
// Self-checking bench for the grid index and cell converter. It writes
// several box settings, runs a table of corner-case requests and then
// random requests under random stalls on both channels. Every result is
// compared field by field with its row expectation or a behavioral model.
// ----------------------------------------------------------------------------
module tb_grid_index_cell_converter_top;

  typedef enum logic [1:0] {
    REQ_IDX_TO_CELL      = 2'd0,
    REQ_CELL_TO_IDX      = 2'd1,
    REQ_FULL_IDX_TO_CELL = 2'd2,
    REQ_CELL_TO_FULL_IDX = 2'd3
  } req_kind_t;

  typedef struct {
    req_kind_t          kind;
    logic [31:0]        lin;
    logic signed [15:0] cx, cy, cz;
  } conv_req_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic [31:0]        index;
    logic               oob;
  } conv_res_t;

  // One directed row: box setting it belongs to, request, optional expectation.
  typedef struct {
    int        setting;
    conv_req_t req;
    bit        typed;
    conv_res_t res;
  } corner_row_t;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [gic_pkg::CFG_IDX_W-1:0]  cfg_index = gic_pkg::CFG_LOWER_X;
  logic [gic_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gic_in_if  in_ch();
  gic_out_if out_ch();

  grid_index_cell_converter_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Bench copy of the box registers.
  logic signed [15:0] box_lower[3] = '{16'sd0, 16'sd0, 16'sd0};
  logic signed [15:0] box_upper[3] = '{16'sd1, 16'sd1, 16'sd1};
  logic [7:0]         box_guard = 8'd0;

  conv_res_t pending_results[$];
  int  error_count = 0;
  int  checked_count = 0;
  int  oob_count = 0;
  int  cycle_count = 0;
  bit  idle_enable = 1'b0;
  int  stall_left = 0;

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_IDX_TO_CELL;
    in_ch.lin_index = '0;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    in_ch.cell_z = '0;
    out_ch.ready = 1'b0;
  end

  // Bounds of one axis, widened by the halo for full-box requests.
  function automatic longint axis_low(int a, bit full);
    return longint'(box_lower[a]) - (full ? longint'(box_guard) : 0);
  endfunction

  function automatic longint axis_high(int a, bit full);
    return longint'(box_upper[a]) + (full ? longint'(box_guard) : 0);
  endfunction

  // Expected result of one request under the current box.
  function automatic conv_res_t convert_request(conv_req_t q);
    longint            lb, ub, c, coord;
    longint            cell_pos[3];
    longint unsigned   factor, lin, idx, span;
    logic signed [15:0] res_coord[3];
    bit                full, oob;
    conv_res_t         r;
    full = q.kind[gic_pkg::REQ_FULL_BIT];
    oob = 1'b0;
    factor = 1;
    idx = 0;
    lin = q.lin;
    res_coord = '{16'sd0, 16'sd0, 16'sd0};
    cell_pos[0] = q.cx; cell_pos[1] = q.cy; cell_pos[2] = q.cz;
    if (!q.kind[gic_pkg::REQ_CELL_BIT]) begin
      for (int a = 0; a < gic_pkg::NUM_DIMS; a++)
        if (axis_high(a, full) - axis_low(a, full) <= 0) oob = 1'b1;
      if (!oob) begin
        for (int a = gic_pkg::NUM_DIMS - 1; a >= 0; a--) begin
          lb = axis_low(a, full);
          span = longint'(axis_high(a, full) - lb);
          coord = longint'((lin / factor) % span) + lb;
          res_coord[a] = coord[15:0];
          factor *= span;
        end
      end
    end else begin
      for (int a = 0; a < gic_pkg::NUM_DIMS; a++) begin
        c = cell_pos[a];
        if (c < axis_low(a, full) || c >= axis_high(a, full)) oob = 1'b1;
      end
      if (!oob) begin
        for (int a = gic_pkg::NUM_DIMS - 1; a >= 0; a--) begin
          lb = axis_low(a, full);
          ub = axis_high(a, full);
          idx += longint'(cell_pos[a] - lb) * factor;
          factor *= longint'(ub - lb);
        end
      end
    end
    r.x = res_coord[0];
    r.y = res_coord[1];
    r.z = res_coord[2];
    r.index = idx[31:0];
    r.oob = oob;
    return r;
  endfunction

  // Writes all seven box registers, one per clock, while the pipe is empty.
  task automatic write_box(int lx, int ly, int lz, int ux, int uy, int uz, int g);
    logic [gic_pkg::CFG_IDX_W-1:0]  idx_list[7];
    logic [gic_pkg::CFG_DATA_W-1:0] val_list[7];
    idx_list = '{gic_pkg::CFG_LOWER_X, gic_pkg::CFG_LOWER_Y, gic_pkg::CFG_LOWER_Z,
                 gic_pkg::CFG_UPPER_X, gic_pkg::CFG_UPPER_Y, gic_pkg::CFG_UPPER_Z,
                 gic_pkg::CFG_GUARD};
    val_list = '{lx[15:0], ly[15:0], lz[15:0], ux[15:0], uy[15:0], uz[15:0],
                 {8'd0, g[7:0]}};
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int k = 0; k < 7; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data <= val_list[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    box_lower = '{lx[15:0], ly[15:0], lz[15:0]};
    box_upper = '{ux[15:0], uy[15:0], uz[15:0]};
    box_guard = g[7:0];
    @(posedge clk);
  endtask

  // Idle length between requests: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_enable || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Presents one request and waits for its transaction.
  task automatic send_request(conv_req_t q, bit typed, conv_res_t typed_res);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= q.kind;
    in_ch.lin_index <= q.lin;
    in_ch.cell_x <= q.cx;
    in_ch.cell_y <= q.cy;
    in_ch.cell_z <= q.cz;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(typed ? typed_res : convert_request(q));
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random request, mostly inside the box so the deep paths are reached.
  function automatic conv_req_t random_request();
    conv_req_t q;
    longint unsigned total;
    longint lb, ub;
    longint cell_pos[3];
    bit full;
    q.kind = req_kind_t'($urandom_range(0, 3));
    full = q.kind[gic_pkg::REQ_FULL_BIT];
    q.lin = $urandom();
    q.cx = 16'($urandom());
    q.cy = 16'($urandom());
    q.cz = 16'($urandom());
    total = 1;
    for (int a = 0; a < gic_pkg::NUM_DIMS; a++) begin
      lb = axis_low(a, full);
      ub = axis_high(a, full);
      total *= (ub > lb) ? longint'(ub - lb) : 1;
      cell_pos[a] = (ub > lb && $urandom_range(0, 99) < 93) ?
                    lb + longint'($urandom() % longint'(ub - lb)) :
                    longint'($signed(q.cx));
      if ($urandom_range(0, 99) < 7) cell_pos[a] = ($urandom_range(0, 1) != 0) ? lb - 1 : ub;
    end
    q.cx = cell_pos[0][15:0];
    q.cy = cell_pos[1][15:0];
    q.cz = cell_pos[2][15:0];
    if ($urandom_range(0, 99) < 85)
      q.lin = (total > 64'hFFFF_FFFF) ? $urandom() : 32'($urandom() % total);
    return q;
  endfunction

  // Result side: random backpressure with occasional long stalls.
  always @(posedge clk) begin
    if (!idle_enable) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                 : $urandom_range(15, 40);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    conv_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        e = pending_results.pop_front();
        checked_count++;
        if (e.oob) oob_count++;
        if (out_ch.out_x !== e.x) begin
          $error("out_x expected %0d actual %0d", e.x, out_ch.out_x);
          error_count++;
        end
        if (out_ch.out_y !== e.y) begin
          $error("out_y expected %0d actual %0d", e.y, out_ch.out_y);
          error_count++;
        end
        if (out_ch.out_z !== e.z) begin
          $error("out_z expected %0d actual %0d", e.z, out_ch.out_z);
          error_count++;
        end
        if (out_ch.out_index !== e.index) begin
          $error("out_index expected %0d actual %0d", e.index, out_ch.out_index);
          error_count++;
        end
        if (out_ch.out_of_bounds !== e.oob) begin
          $error("out_of_bounds expected %0d actual %0d", e.oob, out_ch.out_of_bounds);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic corner_row_t row(int setting, req_kind_t kind, logic [31:0] lin,
                                      int cx, int cy, int cz, bit typed = 1'b0,
                                      int ex = 0, int ey = 0, int ez = 0,
                                      logic [31:0] eidx = 0, bit eoob = 1'b0);
    corner_row_t r;
    r.setting = setting;
    r.req = '{kind, lin, cx[15:0], cy[15:0], cz[15:0]};
    r.typed = typed;
    r.res = '{ex[15:0], ey[15:0], ez[15:0], eidx, eoob};
    return r;
  endfunction

  initial begin
    corner_row_t corner_rows[$];
    conv_res_t   no_res;
    int          sent;
    int          lx, ly, lz;
    no_res = '{16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0};

    // Setting 0 is the reset box (one cell at the origin, no halo).
    corner_rows.push_back(row(0, REQ_IDX_TO_CELL, 32'd0, 0, 0, 0, 1));
    corner_rows.push_back(row(0, REQ_IDX_TO_CELL, 32'hFFFF_FFFF, 0, 0, 0, 1));
    corner_rows.push_back(row(0, REQ_FULL_IDX_TO_CELL, 32'd7, 0, 0, 0, 1));
    corner_rows.push_back(row(0, REQ_CELL_TO_IDX, 0, 0, 0, 0, 1));
    corner_rows.push_back(row(0, REQ_CELL_TO_IDX, 0, 1, 0, 0, 1, 0, 0, 0, 0, 1));
    corner_rows.push_back(row(0, REQ_CELL_TO_FULL_IDX, 0, -32768, 0, 0, 1, 0, 0, 0, 0, 1));
    corner_rows.push_back(row(0, REQ_CELL_TO_FULL_IDX, 0, 0, 0, 32767, 1, 0, 0, 0, 0, 1));
    // Setting 1 is the widest box with the widest halo.
    corner_rows.push_back(row(1, REQ_IDX_TO_CELL, 32'd0, 0, 0, 0));
    corner_rows.push_back(row(1, REQ_IDX_TO_CELL, 32'hFFFF_FFFF, 0, 0, 0));
    corner_rows.push_back(row(1, REQ_FULL_IDX_TO_CELL, 32'd0, 0, 0, 0));
    corner_rows.push_back(row(1, REQ_FULL_IDX_TO_CELL, 32'hFFFF_FFFF, 0, 0, 0));
    corner_rows.push_back(row(1, REQ_CELL_TO_IDX, 0, -32768, -32768, -32768));
    corner_rows.push_back(row(1, REQ_CELL_TO_IDX, 0, 32766, 32766, 32766));
    corner_rows.push_back(row(1, REQ_CELL_TO_IDX, 0, 32767, 0, 0));
    corner_rows.push_back(row(1, REQ_CELL_TO_FULL_IDX, 0, -32768, 32767, -32768));
    corner_rows.push_back(row(1, REQ_CELL_TO_FULL_IDX, 0, 32767, 32767, 32767));
    // Setting 2 is an empty box: index requests flag, cell requests miss.
    corner_rows.push_back(row(2, REQ_IDX_TO_CELL, 32'd3, 0, 0, 0, 1, 0, 0, 0, 0, 1));
    corner_rows.push_back(row(2, REQ_CELL_TO_IDX, 0, 5, 5, 5, 1, 0, 0, 0, 0, 1));
    corner_rows.push_back(row(2, REQ_FULL_IDX_TO_CELL, 32'd3, 0, 0, 0));
    corner_rows.push_back(row(2, REQ_CELL_TO_FULL_IDX, 0, 5, 5, 5));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, one box setting after another.
    for (int s = 0; s < 3; s++) begin
      if (s == 1) write_box(-32768, -32768, -32768, 32767, 32767, 32767, 255);
      if (s == 2) write_box(5, 0, 5, 5, 9, 2, 1);
      foreach (corner_rows[k])
        if (corner_rows[k].setting == s)
          send_request(corner_rows[k].req, corner_rows[k].typed,
                       corner_rows[k].typed ? corner_rows[k].res : no_res);
      in_ch.valid <= 1'b0;
    end

    // Random part: a new box every phase, idling on in most phases.
    sent = 0;
    for (int p = 0; sent < RANDOM_ITEMS; p++) begin
      lx = $signed(16'($urandom()));
      ly = $signed(16'($urandom()));
      lz = $signed(16'($urandom()));
      if (p % 5 == 1) begin
        write_box(-32768, lx, 32767 - 6, -32768 + 3, lx + 4, 32767, 255);
      end else if (p % 5 == 3) begin
        write_box(lx, ly, lz, lx + $urandom_range(0, 200) - 100,
                  ly + $urandom_range(1, 40), lz + $urandom_range(1, 3000),
                  $urandom_range(0, 255));
      end else begin
        write_box(lx, ly, lz, lx + $urandom_range(1, 9), ly + $urandom_range(1, 9),
                  lz + $urandom_range(1, 12), $urandom_range(0, 3));
      end
      idle_enable = (p % 4 != 0);
      for (int k = 0; k < 140 && sent < RANDOM_ITEMS; k++) begin
        send_request(random_request(), 1'b0, no_res);
        sent++;
      end
      in_ch.valid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results over reset, extreme, empty and random boxes,",
             checked_count);
    $display("%0d of them out of bounds, with random stalls on both channels.",
             oob_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
sv/gic_pkg.sv
sv/gic_if.sv
sv/gic_front.sv
sv/gic_stage.sv
sv/grid_index_cell_converter_top.sv
test/tb_grid_index_cell_converter_top.sv
